@@ src/vss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vss_pkg;

   // steal policy codes
   localparam logic [1:0] POLICY_NONE   = 2'd0;
   localparam logic [1:0] POLICY_OLDEST = 2'd1;
   localparam logic [1:0] POLICY_QUIET  = 2'd2;
   localparam logic [1:0] POLICY_FAR    = 2'd3;

   localparam int SLOT_W  = 6;
   localparam int LEVEL_W = 16;
   localparam int TIME_W  = 32;
   localparam int DIST_W  = 32;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               active;
      logic               is_requester;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  finish_time;
      logic [DIST_W-1:0]  dist_sq;
      logic               last_item;
   } record_type;

   typedef struct packed {
      logic              victim_found;
      logic [SLOT_W-1:0] victim_slot;
   } verdict_type;

endpackage

`default_nettype wire

@@ src/vss_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel record request
interface vss_req_if;
   logic                       valid;
   logic                       ready;
   logic [vss_pkg::SLOT_W-1:0]  slot;
   logic                       active;
   logic                       is_requester;
   logic [vss_pkg::LEVEL_W-1:0] level;
   logic [vss_pkg::TIME_W-1:0]  finish_time;
   logic [vss_pkg::DIST_W-1:0]  dist_sq;
   logic                       last_item;

   modport source (output valid, slot, active, is_requester, level, finish_time, dist_sq,
                   last_item, input ready);
   modport sink   (input valid, slot, active, is_requester, level, finish_time, dist_sq,
                   last_item, output ready);
endinterface

// verdict
interface vss_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      victim_found;
   logic [vss_pkg::SLOT_W-1:0] victim_slot;

   modport source (output valid, victim_found, victim_slot, input ready);
   modport sink   (input valid, victim_found, victim_slot, output ready);
endinterface

// policy register write
interface vss_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] policy;

   modport source (output valid, policy, input ready);
   modport sink   (input valid, policy, output ready);
endinterface

`default_nettype wire

@@ src/vss_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vss_scan (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [1:0]           policy,
   input  wire vss_pkg::record_type  rec,
   output vss_pkg::verdict_type      verdict
);

   // a beats b: lower level, or equal level and strictly earlier finish
   function automatic logic quieter(input logic [vss_pkg::LEVEL_W-1:0] al,
                                    input logic [vss_pkg::TIME_W-1:0]  af,
                                    input logic [vss_pkg::LEVEL_W-1:0] bl,
                                    input logic [vss_pkg::TIME_W-1:0]  bf);
      logic r;
      if (al == bl) begin
         r = (af < bf);
      end else begin
         r = (al < bl);
      end
      return r;
   endfunction

   logic                        best_valid_ff, best_valid_in;
   logic [vss_pkg::SLOT_W-1:0]  best_slot_ff, best_slot_in;
   logic [vss_pkg::LEVEL_W-1:0] best_level_ff, best_level_in;
   logic [vss_pkg::TIME_W-1:0]  best_finish_ff, best_finish_in;
   logic [vss_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic                        req_seen_ff, req_seen_in;
   logic [vss_pkg::LEVEL_W-1:0] req_level_ff, req_level_in;
   logic [vss_pkg::TIME_W-1:0]  req_finish_ff, req_finish_in;
   logic [vss_pkg::DIST_W-1:0]  req_dist_ff, req_dist_in;
   logic                        blocked_ff, blocked_in;
   logic                        take;
   logic                        found;

   always_comb begin
      take       = 1'b0;
      blocked_in = blocked_ff;
      unique case (policy)
         vss_pkg::POLICY_NONE: begin
            take = 1'b0;
         end
         vss_pkg::POLICY_OLDEST: begin
            if (!best_valid_ff && !blocked_ff) begin
               if (rec.is_requester) begin
                  blocked_in = 1'b1;
               end else if (rec.active) begin
                  take = 1'b1;
               end
            end
         end
         vss_pkg::POLICY_QUIET: begin
            take = rec.active && (!best_valid_ff ||
                   quieter(rec.level, rec.finish_time, best_level_ff, best_finish_ff));
         end
         vss_pkg::POLICY_FAR: begin
            take = rec.active && (!best_valid_ff || (rec.dist_sq > best_dist_ff));
         end
      endcase

      best_valid_in  = best_valid_ff | take;
      best_slot_in   = take ? rec.slot        : best_slot_ff;
      best_level_in  = take ? rec.level       : best_level_ff;
      best_finish_in = take ? rec.finish_time : best_finish_ff;
      best_dist_in   = take ? rec.dist_sq     : best_dist_ff;
      req_seen_in    = req_seen_ff | rec.is_requester;
      req_level_in   = rec.is_requester ? rec.level       : req_level_ff;
      req_finish_in  = rec.is_requester ? rec.finish_time : req_finish_ff;
      req_dist_in    = rec.is_requester ? rec.dist_sq     : req_dist_ff;

      // verdict from the state including this record
      unique case (policy)
         vss_pkg::POLICY_NONE:   found = 1'b0;
         vss_pkg::POLICY_OLDEST: found = best_valid_in;
         vss_pkg::POLICY_QUIET:  found = best_valid_in && (!req_seen_in ||
                                 quieter(best_level_in, best_finish_in,
                                         req_level_in, req_finish_in));
         vss_pkg::POLICY_FAR:    found = best_valid_in &&
                                 (!req_seen_in || (best_dist_in > req_dist_in));
      endcase

      verdict.victim_found = found;
      verdict.victim_slot  = found ? best_slot_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && rec.last_item)) begin
         best_valid_ff  <= 1'b0;
         best_slot_ff   <= '0;
         best_level_ff  <= '0;
         best_finish_ff <= '0;
         best_dist_ff   <= '0;
         req_seen_ff    <= 1'b0;
         req_level_ff   <= '0;
         req_finish_ff  <= '0;
         req_dist_ff    <= '0;
         blocked_ff     <= 1'b0;
      end else if (step) begin
         best_valid_ff  <= best_valid_in;
         best_slot_ff   <= best_slot_in;
         best_level_ff  <= best_level_in;
         best_finish_ff <= best_finish_in;
         best_dist_ff   <= best_dist_in;
         req_seen_ff    <= req_seen_in;
         req_level_ff   <= req_level_in;
         req_finish_ff  <= req_finish_in;
         req_dist_ff    <= req_dist_in;
         blocked_ff     <= blocked_in;
      end
   end

endmodule

`default_nettype wire

@@ src/voice_steal_selector.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Voice steal selector.
// req_ch carries one channel record per request, in list order; the request
// with last_item set closes the scan. rsp_ch carries one verdict per scan
// (victim_found, victim_slot; slot reads 0 when nothing is to be stolen).
// csr_ch writes the 2-bit policy: none, oldest, quietest, farthest. It is
// always ready and should only be written between scans.
// A request is registered on acceptance and judged against the running
// candidate when processed; a last_item record also loads the verdict
// register, which drives rsp_ch. Throughput: one request per cycle unless a
// last_item record waits on the verdict register; only the compare of one
// record against the running best and requester record sits between registers.
// Reset (synchronous, active high) clears the scan state, empties both
// registers and sets the policy to none.
// Receiver stall: records keep flowing while a verdict waits; only a
// last_item record holds in the input register until the verdict register
// is free, and req_ch.ready drops behind it.

module voice_steal_selector (
   input  wire logic   clock,
   input  wire logic   reset,
   vss_req_if.sink     req_ch,
   vss_rsp_if.source   rsp_ch,
   vss_csr_if.sink     csr_ch
);

   logic [1:0]           policy_ff;
   logic                 in_valid_ff;
   vss_pkg::record_type  in_rec_ff;
   logic                 out_valid_ff;
   vss_pkg::verdict_type out_ff;
   vss_pkg::verdict_type verdict;
   logic                 proc;
   logic                 req_take;

   // policy register
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= vss_pkg::POLICY_NONE;
      end else if (csr_ch.valid) begin
         policy_ff <= csr_ch.policy;
      end
   end

   // a record is processed unless it closes the scan and the verdict slot is full and not being taken
   assign proc     = in_valid_ff && (!in_rec_ff.last_item || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || proc;
   assign req_take = req_ch.valid && req_ch.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_rec_ff.slot         <= req_ch.slot;
         in_rec_ff.active       <= req_ch.active;
         in_rec_ff.is_requester <= req_ch.is_requester;
         in_rec_ff.level        <= req_ch.level;
         in_rec_ff.finish_time  <= req_ch.finish_time;
         in_rec_ff.dist_sq      <= req_ch.dist_sq;
         in_rec_ff.last_item    <= req_ch.last_item;
      end
   end

   vss_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (proc),
      .policy  (policy_ff),
      .rec     (in_rec_ff),
      .verdict (verdict)
   );

   // verdict register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc && in_rec_ff.last_item) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && in_rec_ff.last_item) begin
         out_ff <= verdict;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.victim_found = out_ff.victim_found;
   assign rsp_ch.victim_slot  = out_ff.victim_slot;

   // a verdict only ever follows a closing record
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(proc && in_rec_ff.last_item))
      else $error("verdict raised without a closing record");

   // back-pressure only from a closing record blocked by a waiting verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (in_valid_ff && in_rec_ff.last_item && out_valid_ff && !rsp_ch.ready))
      else $error("request side stalled without cause");

   // no victim means a zero slot
   a_zero_slot: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.victim_found) |-> (out_ff.victim_slot == '0))
      else $error("slot reported without a victim");

endmodule

`default_nettype wire
